// ----- src/hrb_pkg.sv -----
package hrb_pkg;

    localparam int KEY_SLOTS_DEF         = 6;
    localparam int MEDIA_SLOTS_DEF       = 6;
    localparam int KB_QUEUE_DEPTH_DEF    = 8;
    localparam int MEDIA_QUEUE_DEPTH_DEF = 8;
    localparam int NUM_SLOTS             = 6;
    localparam int NUM_MOD_BITS          = 8;

    localparam logic [7:0]  PAGE_KEYBOARD = 8'd7;
    localparam logic [7:0]  PAGE_CONSUMER = 8'd12;
    localparam logic [15:0] MOD_KEY_FIRST = 16'h00E0;
    localparam logic [15:0] MOD_KEY_LAST  = 16'h00E7;

    typedef enum logic [1:0] {
        KIND_STATUS   = 2'd0,
        KIND_KEYBOARD = 2'd1,
        KIND_CONSUMER = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PG_OTHER,
        PG_KEYBOARD,
        PG_CONSUMER
    } t_page;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic        tick;
        t_page       page;
        logic        is_mod;
        logic [2:0]  mod_sel;
        logic [15:0] key;
        logic        pressed;
        logic [7:0]  emods;
        logic [7:0]  imods;
        logic        active;
        logic        quiet;
    } t_cmd;

    typedef struct packed {
        t_kind                        kind;
        logic [7:0]                   mods;
        logic [NUM_SLOTS-1:0][15:0]   slots;
        logic                         handled;
        logic                         last;
    } t_res;

endpackage

// ----- src/hid_report_builder_with_quiet_queue.sv -----
// Flow: input transfers pass a two-entry command FIFO to the back-end sequencer (IDLE,
// UPDATE, EMIT); each yields N = 1..18 results, one per cycle while the output is not
// stalled. The next command is popped only after the last result of the current one.
// Reset: synchronous active low; clears slots, counts, queue fills and control state.
// Snapshot queue contents are not cleared; no clearing pass is needed.
module hid_report_builder_with_quiet_queue #(
    parameter int KEY_SLOTS         = hrb_pkg::KEY_SLOTS_DEF,
    parameter int MEDIA_SLOTS       = hrb_pkg::MEDIA_SLOTS_DEF,
    parameter int KB_QUEUE_DEPTH    = hrb_pkg::KB_QUEUE_DEPTH_DEF,
    parameter int MEDIA_QUEUE_DEPTH = hrb_pkg::MEDIA_QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_usage_page,
    input  logic [15:0] i_keycode,
    input  logic        i_pressed,
    input  logic [7:0]  i_explicit_mods,
    input  logic [7:0]  i_implicit_mods,
    input  logic        i_link_active,
    input  logic        i_link_quiet,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_report_kind,
    output logic [7:0]  o_report_mods,
    output logic [15:0] o_slot_0,
    output logic [15:0] o_slot_1,
    output logic [15:0] o_slot_2,
    output logic [15:0] o_slot_3,
    output logic [15:0] o_slot_4,
    output logic [15:0] o_slot_5,
    output logic        o_handled,
    output logic        o_last
);
    import hrb_pkg::*;

    logic fifo_ready, push, pop, cmd_valid;
    t_cmd front_cmd, back_cmd;
    t_res res;

    hrb_front u_front (
        .i_valid         (i_valid),
        .i_fifo_ready    (fifo_ready),
        .i_req_type      (i_req_type),
        .i_usage_page    (i_usage_page),
        .i_keycode       (i_keycode),
        .i_pressed       (i_pressed),
        .i_explicit_mods (i_explicit_mods),
        .i_implicit_mods (i_implicit_mods),
        .i_link_active   (i_link_active),
        .i_link_quiet    (i_link_quiet),
        .o_ready         (o_ready),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    hrb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (fifo_ready),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_cmd   (back_cmd)
    );

    hrb_back #(
        .KEY_SLOTS         (KEY_SLOTS),
        .MEDIA_SLOTS       (MEDIA_SLOTS),
        .KB_QUEUE_DEPTH    (KB_QUEUE_DEPTH),
        .MEDIA_QUEUE_DEPTH (MEDIA_QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (pop),
        .o_res       (res),
        .o_valid     (o_valid),
        .i_ready     (i_ready)
    );

    assign o_report_kind = res.kind;
    assign o_report_mods = res.mods;
    assign o_slot_0      = res.slots[0];
    assign o_slot_1      = res.slots[1];
    assign o_slot_2      = res.slots[2];
    assign o_slot_3      = res.slots[3];
    assign o_slot_4      = res.slots[4];
    assign o_slot_5      = res.slots[5];
    assign o_handled     = res.handled;
    assign o_last        = res.last;

endmodule

// ----- src/hrb_front.sv -----
module hrb_front (
    input  logic          i_valid,
    input  logic          i_fifo_ready,
    input  logic          i_req_type,
    input  logic [7:0]    i_usage_page,
    input  logic [15:0]   i_keycode,
    input  logic          i_pressed,
    input  logic [7:0]    i_explicit_mods,
    input  logic [7:0]    i_implicit_mods,
    input  logic          i_link_active,
    input  logic          i_link_quiet,
    output logic          o_ready,
    output logic          o_push,
    output hrb_pkg::t_cmd o_cmd
);
    import hrb_pkg::*;

    assign o_ready = i_fifo_ready;
    assign o_push  = i_valid & i_fifo_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.tick    = i_req_type;
        o_cmd.key     = i_keycode;
        o_cmd.pressed = i_pressed;
        o_cmd.emods   = i_explicit_mods;
        o_cmd.imods   = i_implicit_mods;
        o_cmd.active  = i_link_active;
        o_cmd.quiet   = i_link_quiet;
        o_cmd.mod_sel = i_keycode[2:0];
        o_cmd.is_mod  = i_keycode inside {[MOD_KEY_FIRST:MOD_KEY_LAST]};
        case (i_usage_page)
            PAGE_KEYBOARD: o_cmd.page = PG_KEYBOARD;
            PAGE_CONSUMER: o_cmd.page = PG_CONSUMER;
            default:       o_cmd.page = PG_OTHER;
        endcase
    end

endmodule

// ----- src/hrb_fifo.sv -----
module hrb_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hrb_pkg::t_cmd i_cmd,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output hrb_pkg::t_cmd o_cmd
);
    import hrb_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop) r_rptr <= ~r_rptr;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_cmd;
    end

endmodule

// ----- src/hrb_back.sv -----
module hrb_back #(
    parameter int KEY_SLOTS         = hrb_pkg::KEY_SLOTS_DEF,
    parameter int MEDIA_SLOTS       = hrb_pkg::MEDIA_SLOTS_DEF,
    parameter int KB_QUEUE_DEPTH    = hrb_pkg::KB_QUEUE_DEPTH_DEF,
    parameter int MEDIA_QUEUE_DEPTH = hrb_pkg::MEDIA_QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  hrb_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output hrb_pkg::t_res o_res,
    output logic          o_valid,
    input  logic          i_ready
);
    import hrb_pkg::*;

    localparam int KIW = (KB_QUEUE_DEPTH > 1) ? $clog2(KB_QUEUE_DEPTH) : 1;
    localparam int KCW = $clog2(KB_QUEUE_DEPTH + 1);
    localparam int MIW = (MEDIA_QUEUE_DEPTH > 1) ? $clog2(MEDIA_QUEUE_DEPTH) : 1;
    localparam int MCW = $clog2(MEDIA_QUEUE_DEPTH + 1);
    localparam logic [KIW:0] KD = (KIW+1)'(KB_QUEUE_DEPTH);
    localparam logic [MIW:0] MD = (MIW+1)'(MEDIA_QUEUE_DEPTH);

    t_state r_state;
    t_state n_state;
    t_cmd   r_cmd;

    logic [KEY_SLOTS-1:0][7:0]     r_keys;
    logic [KEY_SLOTS-1:0][7:0]     n_keys;
    logic [MEDIA_SLOTS-1:0][15:0]  r_media;
    logic [MEDIA_SLOTS-1:0][15:0]  n_media;
    logic [NUM_MOD_BITS-1:0][7:0]  r_ecnt;
    logic [NUM_MOD_BITS-1:0][7:0]  n_ecnt;
    logic [NUM_MOD_BITS-1:0][7:0]  r_icnt;
    logic [NUM_MOD_BITS-1:0][7:0]  n_icnt;

    logic [7:0]                    r_kq_mods [KB_QUEUE_DEPTH];
    logic [KEY_SLOTS-1:0][7:0]     r_kq_keys [KB_QUEUE_DEPTH];
    logic [MEDIA_SLOTS-1:0][15:0]  r_mq      [MEDIA_QUEUE_DEPTH];

    logic [KCW-1:0] r_kfill, r_kn, r_ki, kfill_eff, k_newfill, n_kn, nk_i;
    logic [MCW-1:0] r_mfill, r_mn, r_mi, mfill_eff, m_newfill, n_mn, nm_i;
    logic [KIW-1:0] r_khead, k_newhead, k_widx, k_ridx;
    logic [MIW-1:0] r_mhead, m_newhead, m_widx, m_ridx;
    logic [KIW:0]   k_s1, k_s2, k_s3;
    logic [MIW:0]   m_s1, m_s2, m_s3;

    logic r_prev, r_handled, r_kl, r_ml, r_st, r_ov;
    t_res r_out;
    t_res e_res;

    logic        upd, ev, falling, kb_send, md_send, kb_drain, md_drain, kb_append, md_append;
    logic        k_hit, k_found, m_hit, m_found, do_count;
    logic [7:0]  e_vec, i_vec, n_mods, cur_mods;
    logic        can_load, p_kd, p_md, any_pend, last;
    logic        sel_kd, sel_kl, sel_md, sel_ml, sel_st, nkl, nml, nst;
    logic [KEY_SLOTS-1:0][7:0]    k_rkeys;
    logic [MEDIA_SLOTS-1:0][15:0] m_rslots;

    assign upd      = (r_state == ST_UPDATE);
    assign ev       = !r_cmd.tick;
    assign falling  = ev && r_prev && !r_cmd.active;
    assign kfill_eff = falling ? '0 : r_kfill;
    assign mfill_eff = falling ? '0 : r_mfill;
    assign kb_send  = ev && r_cmd.active && ((r_cmd.page == PG_KEYBOARD) ||
                      ((r_cmd.page == PG_CONSUMER) && ((r_cmd.emods | r_cmd.imods) != 8'd0)));
    assign md_send  = ev && r_cmd.active && (r_cmd.page == PG_CONSUMER);
    assign kb_drain = !r_cmd.quiet && (r_cmd.tick || kb_send);
    assign md_drain = !r_cmd.quiet && (r_cmd.tick || md_send);
    assign kb_append = kb_send && r_cmd.quiet;
    assign md_append = md_send && r_cmd.quiet;
    assign n_kn     = kb_drain ? kfill_eff : '0;
    assign n_mn     = md_drain ? mfill_eff : '0;
    assign do_count = upd && ev && (r_cmd.page != PG_OTHER);
    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;

    // slot tracking
    always_comb begin
        n_keys  = r_keys;
        k_hit   = 1'b0;
        k_found = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (r_keys[i] == r_cmd.key[7:0]) k_hit = 1'b1;
        end
        if (upd && ev && (r_cmd.page == PG_KEYBOARD) && !r_cmd.is_mod) begin
            if (r_cmd.pressed) begin
                if (!k_hit) begin
                    for (int i = 0; i < KEY_SLOTS; i++) begin
                        if (!k_found && (r_keys[i] == 8'd0)) begin
                            n_keys[i] = r_cmd.key[7:0];
                            k_found   = 1'b1;
                        end
                    end
                end
            end else begin
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    if (r_keys[i] == r_cmd.key[7:0]) n_keys[i] = 8'd0;
                end
            end
        end
    end

    always_comb begin
        n_media = r_media;
        m_hit   = 1'b0;
        m_found = 1'b0;
        for (int i = 0; i < MEDIA_SLOTS; i++) begin
            if (r_media[i] == r_cmd.key) m_hit = 1'b1;
        end
        if (upd && ev && (r_cmd.page == PG_CONSUMER)) begin
            if (r_cmd.pressed) begin
                if (!m_hit) begin
                    for (int i = 0; i < MEDIA_SLOTS; i++) begin
                        if (!m_found && (r_media[i] == 16'd0)) begin
                            n_media[i] = r_cmd.key;
                            m_found    = 1'b1;
                        end
                    end
                end
            end else begin
                for (int i = 0; i < MEDIA_SLOTS; i++) begin
                    if (r_media[i] == r_cmd.key) n_media[i] = 16'd0;
                end
            end
        end
    end

    // modifier reference counts, saturating
    always_comb begin
        if ((r_cmd.page == PG_KEYBOARD) && r_cmd.is_mod) begin
            e_vec = 8'd1 << r_cmd.mod_sel;
            i_vec = 8'd0;
        end else begin
            e_vec = r_cmd.emods;
            i_vec = r_cmd.imods;
        end
        n_ecnt = r_ecnt;
        n_icnt = r_icnt;
        if (do_count) begin
            for (int b = 0; b < NUM_MOD_BITS; b++) begin
                if (e_vec[b]) begin
                    if (r_cmd.pressed) begin
                        if (r_ecnt[b] != 8'hFF) n_ecnt[b] = r_ecnt[b] + 8'd1;
                    end else if (r_ecnt[b] != 8'd0) begin
                        n_ecnt[b] = r_ecnt[b] - 8'd1;
                    end
                end
                if (i_vec[b]) begin
                    if (r_cmd.pressed) begin
                        if (r_icnt[b] != 8'hFF) n_icnt[b] = r_icnt[b] + 8'd1;
                    end else if (r_icnt[b] != 8'd0) begin
                        n_icnt[b] = r_icnt[b] - 8'd1;
                    end
                end
            end
        end
        for (int b = 0; b < NUM_MOD_BITS; b++) begin
            n_mods[b]   = (n_ecnt[b] != 8'd0) || (n_icnt[b] != 8'd0);
            cur_mods[b] = (r_ecnt[b] != 8'd0) || (r_icnt[b] != 8'd0);
        end
    end

    // ring positions, drop oldest when full
    always_comb begin
        k_s1 = {1'b0, r_khead} + (KIW+1)'(1);
        k_s1 = (k_s1 >= KD) ? k_s1 - KD : k_s1;
        if (kfill_eff == KCW'(KB_QUEUE_DEPTH)) begin
            k_newhead = k_s1[KIW-1:0];
            k_s2      = k_s1 + (KIW+1)'(KB_QUEUE_DEPTH - 1);
            k_newfill = kfill_eff;
        end else begin
            k_newhead = r_khead;
            k_s2      = {1'b0, r_khead} + (KIW+1)'(kfill_eff);
            k_newfill = kfill_eff + KCW'(1);
        end
        k_s2   = (k_s2 >= KD) ? k_s2 - KD : k_s2;
        k_widx = k_s2[KIW-1:0];
        k_s3   = {1'b0, r_khead} + (KIW+1)'(r_ki);
        k_s3   = (k_s3 >= KD) ? k_s3 - KD : k_s3;
        k_ridx = k_s3[KIW-1:0];

        m_s1 = {1'b0, r_mhead} + (MIW+1)'(1);
        m_s1 = (m_s1 >= MD) ? m_s1 - MD : m_s1;
        if (mfill_eff == MCW'(MEDIA_QUEUE_DEPTH)) begin
            m_newhead = m_s1[MIW-1:0];
            m_s2      = m_s1 + (MIW+1)'(MEDIA_QUEUE_DEPTH - 1);
            m_newfill = mfill_eff;
        end else begin
            m_newhead = r_mhead;
            m_s2      = {1'b0, r_mhead} + (MIW+1)'(mfill_eff);
            m_newfill = mfill_eff + MCW'(1);
        end
        m_s2   = (m_s2 >= MD) ? m_s2 - MD : m_s2;
        m_widx = m_s2[MIW-1:0];
        m_s3   = {1'b0, r_mhead} + (MIW+1)'(r_mi);
        m_s3   = (m_s3 >= MD) ? m_s3 - MD : m_s3;
        m_ridx = m_s3[MIW-1:0];
    end

    // result sequencing
    assign can_load = !r_ov || i_ready;
    assign p_kd     = (r_ki != r_kn);
    assign p_md     = (r_mi != r_mn);
    assign any_pend = p_kd || r_kl || p_md || r_ml || r_st;
    assign sel_kd   = p_kd;
    assign sel_kl   = !p_kd && r_kl;
    assign sel_md   = !p_kd && !r_kl && p_md;
    assign sel_ml   = !p_kd && !r_kl && !p_md && r_ml;
    assign sel_st   = !p_kd && !r_kl && !p_md && !r_ml && r_st;
    assign nk_i     = sel_kd ? r_ki + KCW'(1) : r_ki;
    assign nm_i     = sel_md ? r_mi + MCW'(1) : r_mi;
    assign nkl      = r_kl && !sel_kl;
    assign nml      = r_ml && !sel_ml;
    assign nst      = r_st && !sel_st;
    assign last     = (nk_i == r_kn) && !nkl && (nm_i == r_mn) && !nml && !nst;
    assign k_rkeys  = r_kq_keys[k_ridx];
    assign m_rslots = r_mq[m_ridx];

    always_comb begin
        e_res         = '0;
        e_res.kind    = KIND_STATUS;
        e_res.handled = r_handled;
        e_res.last    = last;
        if (sel_kd || sel_kl) begin
            e_res.kind = KIND_KEYBOARD;
            e_res.mods = sel_kd ? r_kq_mods[k_ridx] : cur_mods;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                e_res.slots[j] = {8'h00, (sel_kd ? k_rkeys[j] : r_keys[j])};
            end
        end else if (sel_md || sel_ml) begin
            e_res.kind = KIND_CONSUMER;
            for (int j = 0; j < MEDIA_SLOTS; j++) begin
                e_res.slots[j] = sel_md ? m_rslots[j] : r_media[j];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_cmd_valid) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_EMIT;
            ST_EMIT:   if (can_load && any_pend && last) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys    <= '0;
            r_media   <= '0;
            r_ecnt    <= '0;
            r_icnt    <= '0;
            r_kfill   <= '0;
            r_mfill   <= '0;
            r_khead   <= '0;
            r_mhead   <= '0;
            r_prev    <= 1'b0;
            r_handled <= 1'b0;
            r_kn      <= '0;
            r_ki      <= '0;
            r_mn      <= '0;
            r_mi      <= '0;
            r_kl      <= 1'b0;
            r_ml      <= 1'b0;
            r_st      <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_ready && !((r_state == ST_EMIT) && can_load && any_pend)) r_ov <= 1'b0;
            if (upd) begin
                r_keys    <= n_keys;
                r_media   <= n_media;
                r_ecnt    <= n_ecnt;
                r_icnt    <= n_icnt;
                if (ev) r_prev <= r_cmd.active;
                r_handled <= ev && r_cmd.active && (r_cmd.page != PG_OTHER);
                r_kn      <= n_kn;
                r_mn      <= n_mn;
                r_ki      <= '0;
                r_mi      <= '0;
                r_kl      <= kb_send && !r_cmd.quiet;
                r_ml      <= md_send && !r_cmd.quiet;
                r_st      <= (n_kn == '0) && (n_mn == '0) &&
                             !(kb_send && !r_cmd.quiet) && !(md_send && !r_cmd.quiet);
                r_kfill   <= kb_drain ? '0 : (kb_append ? k_newfill : kfill_eff);
                r_mfill   <= md_drain ? '0 : (md_append ? m_newfill : mfill_eff);
                if (kb_append) r_khead <= k_newhead;
                if (md_append) r_mhead <= m_newhead;
            end
            if ((r_state == ST_EMIT) && can_load && any_pend) begin
                r_ov <= 1'b1;
                r_ki <= nk_i;
                r_mi <= nm_i;
                r_kl <= nkl;
                r_ml <= nml;
                r_st <= nst;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) r_cmd <= i_cmd;
        if ((r_state == ST_EMIT) && can_load && any_pend) r_out <= e_res;
        if (upd && kb_append) begin
            r_kq_mods[k_widx] <= n_mods;
            r_kq_keys[k_widx] <= n_keys;
        end
        if (upd && md_append) r_mq[m_widx] <= n_media;
    end

    assign o_res   = r_out;
    assign o_valid = r_ov;

`ifndef ASSERT_OFF
    a_kfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kfill <= KCW'(KB_QUEUE_DEPTH)) else $error("kb queue fill out of range");
    a_mfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mfill <= MCW'(MEDIA_QUEUE_DEPTH)) else $error("media queue fill out of range");
    a_idle_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_kl && !r_ml && !r_st && (r_ki == r_kn) && (r_mi == r_mn)))
        else $error("results pending in idle");
    a_pop_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_state == ST_UPDATE)) else $error("pop without update");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import hrb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_RANDOM       = 173;

    typedef struct {
        logic        req_type;
        logic [7:0]  page;
        logic [15:0] key;
        logic        pressed;
        logic [7:0]  emods;
        logic [7:0]  imods;
        logic        active;
        logic        quiet;
    } t_event;

    typedef struct {
        t_kind       kind;
        logic [7:0]  mods;
        logic [15:0] slots [NUM_SLOTS];
        logic        handled;
        logic        last;
    } t_report;

    typedef struct {
        logic [7:0]  mods;
        logic [15:0] slots [NUM_SLOTS];
    } t_snap;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_req_type;
    logic [7:0]  i_usage_page;
    logic [15:0] i_keycode;
    logic        i_pressed;
    logic [7:0]  i_explicit_mods;
    logic [7:0]  i_implicit_mods;
    logic        i_link_active;
    logic        i_link_quiet;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_report_kind;
    logic [7:0]  o_report_mods;
    logic [15:0] o_slot_0, o_slot_1, o_slot_2, o_slot_3, o_slot_4, o_slot_5;
    logic        o_handled;
    logic        o_last;

    hid_report_builder_with_quiet_queue u_top (.*);

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    t_event  pending_events[$];
    t_report expected_reports[$];

    logic [7:0]  key_slots [NUM_SLOTS];
    logic [15:0] media_slots [NUM_SLOTS];
    logic [7:0]  exp_cnt [NUM_MOD_BITS];
    logic [7:0]  imp_cnt [NUM_MOD_BITS];
    logic [7:0]  exp_bits, imp_bits;
    t_snap       kb_queue[$];
    t_snap       media_queue[$];
    logic        prev_active;

    int errors;
    int n_events;
    int n_reports;
    int n_queued_replays;
    int idle_cycles;
    bit stim_done;
    bit timed_out;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        errors++;
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    task automatic push_report(input t_kind kind, input t_snap s, input logic handled);
        t_report r;
        r.kind = kind;
        r.mods = (kind == KIND_KEYBOARD) ? s.mods : 8'd0;
        r.slots = s.slots;
        r.handled = handled;
        r.last = 1'b0;
        expected_reports.push_back(r);
    endtask

    task automatic adjust_counts(input bit up, input logic [7:0] m, input bit implicit);
        for (int b = 0; b < NUM_MOD_BITS; b++) begin
            if (m[b]) begin
                if (implicit) begin
                    if (up) begin
                        if (imp_cnt[b] == 8'd0) imp_bits[b] = 1'b1;
                        if (imp_cnt[b] != 8'd255) imp_cnt[b]++;
                    end else if (imp_cnt[b] != 8'd0) begin
                        imp_cnt[b]--;
                        if (imp_cnt[b] == 8'd0) imp_bits[b] = 1'b0;
                    end
                end else begin
                    if (up) begin
                        if (exp_cnt[b] == 8'd0) exp_bits[b] = 1'b1;
                        if (exp_cnt[b] != 8'd255) exp_cnt[b]++;
                    end else if (exp_cnt[b] != 8'd0) begin
                        exp_cnt[b]--;
                        if (exp_cnt[b] == 8'd0) exp_bits[b] = 1'b0;
                    end
                end
            end
        end
    endtask

    task automatic replay_keyboard(input logic handled);
        foreach (kb_queue[i]) push_report(KIND_KEYBOARD, kb_queue[i], handled);
        n_queued_replays += kb_queue.size();
        kb_queue.delete();
    endtask

    task automatic replay_consumer(input logic handled);
        foreach (media_queue[i]) push_report(KIND_CONSUMER, media_queue[i], handled);
        n_queued_replays += media_queue.size();
        media_queue.delete();
    endtask

    task automatic post_kb_report(input logic quiet, input logic handled);
        t_snap s;
        s.mods = exp_bits | imp_bits;
        foreach (s.slots[i]) s.slots[i] = {8'd0, key_slots[i]};
        if (quiet) begin
            if (kb_queue.size() >= KB_QUEUE_DEPTH_DEF) void'(kb_queue.pop_front());
            kb_queue.push_back(s);
        end else begin
            replay_keyboard(handled);
            push_report(KIND_KEYBOARD, s, handled);
        end
    endtask

    task automatic post_media_report(input logic quiet, input logic handled);
        t_snap s;
        s.mods = 8'd0;
        s.slots = media_slots;
        if (quiet) begin
            if (media_queue.size() >= MEDIA_QUEUE_DEPTH_DEF) void'(media_queue.pop_front());
            media_queue.push_back(s);
        end else begin
            replay_consumer(handled);
            push_report(KIND_CONSUMER, s, handled);
        end
    endtask

    task automatic predict_reports(input t_event e);
        logic   handled;
        int     prior_count;
        bit     found;
        t_snap  z;
        handled = 1'b0;
        prior_count = expected_reports.size();
        if (e.req_type) begin
            if (!e.quiet) begin
                replay_keyboard(1'b0);
                replay_consumer(1'b0);
            end
        end else begin
            if (prev_active && !e.active) begin
                kb_queue.delete();
                media_queue.delete();
            end
            prev_active = e.active;
            if (e.page == PAGE_KEYBOARD) begin
                handled = e.active;
                if (e.key >= MOD_KEY_FIRST && e.key <= MOD_KEY_LAST) begin
                    adjust_counts(e.pressed, 8'd1 << (e.key - MOD_KEY_FIRST), 1'b0);
                end else begin
                    if (e.pressed) begin
                        found = 1'b0;
                        foreach (key_slots[i]) if (key_slots[i] == e.key[7:0]) found = 1'b1;
                        foreach (key_slots[i]) begin
                            if (!found && key_slots[i] == 8'd0) begin
                                key_slots[i] = e.key[7:0];
                                found = 1'b1;
                            end
                        end
                    end else begin
                        foreach (key_slots[i])
                            if (key_slots[i] == e.key[7:0]) key_slots[i] = 8'd0;
                    end
                    adjust_counts(e.pressed, e.emods, 1'b0);
                    adjust_counts(e.pressed, e.imods, 1'b1);
                end
                if (e.active) post_kb_report(e.quiet, handled);
            end else if (e.page == PAGE_CONSUMER) begin
                handled = e.active;
                if (e.pressed) begin
                    found = 1'b0;
                    foreach (media_slots[i]) if (media_slots[i] == e.key) found = 1'b1;
                    foreach (media_slots[i]) begin
                        if (!found && media_slots[i] == 16'd0) begin
                            media_slots[i] = e.key;
                            found = 1'b1;
                        end
                    end
                end else begin
                    foreach (media_slots[i]) if (media_slots[i] == e.key) media_slots[i] = 16'd0;
                end
                adjust_counts(e.pressed, e.emods, 1'b0);
                adjust_counts(e.pressed, e.imods, 1'b1);
                if (e.active) begin
                    if (e.emods != 8'd0 || e.imods != 8'd0) post_kb_report(e.quiet, handled);
                    post_media_report(e.quiet, handled);
                end
            end
        end
        if (expected_reports.size() == prior_count) begin
            z.mods = 8'd0;
            foreach (z.slots[i]) z.slots[i] = 16'd0;
            push_report(KIND_STATUS, z, handled);
        end
        expected_reports[$].last = 1'b1;
    endtask

    function automatic t_event make_event(input logic req, input logic [7:0] page,
                                          input logic [15:0] key, input logic pr,
                                          input logic [7:0] em, input logic [7:0] im,
                                          input logic act, input logic qt);
        t_event e;
        e.req_type = req;
        e.page = page;
        e.key = key;
        e.pressed = pr;
        e.emods = em;
        e.imods = im;
        e.active = act;
        e.quiet = qt;
        return e;
    endfunction

    function automatic t_event random_event(input logic act, input logic qt);
        logic [15:0] key;
        logic [7:0]  page;
        int          sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            page = PAGE_KEYBOARD;
            case ($urandom_range(0, 3))
                0: key = MOD_KEY_FIRST + 16'($urandom_range(0, 7));
                1: key = 16'($urandom);
                default: key = 16'($urandom_range(4, 12));
            endcase
        end else if (sel < 80) begin
            page = PAGE_CONSUMER;
            key = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range('hE0, 'hE9));
        end else if (sel < 88) begin
            page = 8'($urandom);
            key = 16'($urandom);
        end else begin
            return make_event(1'b1, 8'($urandom), 16'($urandom), 1'($urandom), 8'($urandom),
                              8'($urandom), 1'($urandom), qt);
        end
        return make_event(1'b0, page, key, 1'($urandom),
                          ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'd0,
                          ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'd0, act, qt);
    endfunction

    initial begin
        logic act, qt;
        // directed: extremes, modifiers, queue overflow, replay, falling edge
        pending_events.push_back(make_event(1'b0, PAGE_KEYBOARD, 16'h0004, 1'b1, 8'hFF, 8'hFF,
                                            1'b1, 1'b0));
        pending_events.push_back(make_event(1'b0, PAGE_KEYBOARD, 16'hFF05, 1'b1, 8'h00, 8'h00,
                                            1'b1, 1'b0));
        pending_events.push_back(make_event(1'b0, PAGE_KEYBOARD, 16'h0004, 1'b1, 8'h00, 8'h00,
                                            1'b1, 1'b0));
        pending_events.push_back(make_event(1'b0, PAGE_KEYBOARD, MOD_KEY_FIRST, 1'b1, 8'h00,
                                            8'h00, 1'b1, 1'b0));
        pending_events.push_back(make_event(1'b0, PAGE_KEYBOARD, MOD_KEY_LAST, 1'b0, 8'h00,
                                            8'h00, 1'b1, 1'b0));
        pending_events.push_back(make_event(1'b0, PAGE_KEYBOARD, 16'hFFE0, 1'b1, 8'h0F, 8'hF0,
                                            1'b1, 1'b0));
        for (int i = 0; i < 7; i++)
            pending_events.push_back(make_event(1'b0, PAGE_CONSUMER, 16'(16'h00E9 + i), 1'b1,
                                                8'h00, 8'h00, 1'b1, 1'b0));
        pending_events.push_back(make_event(1'b0, PAGE_CONSUMER, 16'hFFFF, 1'b0, 8'hFF, 8'h00,
                                            1'b1, 1'b1));
        for (int i = 0; i < 9; i++)
            pending_events.push_back(make_event(1'b0, PAGE_KEYBOARD, 16'(16'h0010 + i), i[0],
                                                8'h00, 8'h00, 1'b1, 1'b1));
        pending_events.push_back(make_event(1'b1, 8'hFF, 16'hFFFF, 1'b1, 8'hFF, 8'hFF,
                                            1'b1, 1'b1));
        pending_events.push_back(make_event(1'b1, 8'h00, 16'h0000, 1'b0, 8'h00, 8'h00,
                                            1'b0, 1'b0));
        pending_events.push_back(make_event(1'b0, 8'hFF, 16'hFFFF, 1'b1, 8'hFF, 8'hFF,
                                            1'b0, 1'b0));
        pending_events.push_back(make_event(1'b0, PAGE_KEYBOARD, 16'h0000, 1'b0, 8'h00, 8'h00,
                                            1'b0, 1'b1));
        act = 1'b1;
        qt = 1'b0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 9) == 0) act = ~act;
            if ($urandom_range(0, 5) == 0) qt = ~qt;
            pending_events.push_back(random_event(act, qt));
        end
    end

    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                predict_reports(pending_events.pop_front());
                n_events++;
            end
            if (gap_left > 0) begin
                i_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_events.size() > 0) begin
                t_event e;
                e = pending_events[0];
                i_valid <= 1'b1;
                i_req_type <= e.req_type;
                i_usage_page <= e.page;
                i_keycode <= e.key;
                i_pressed <= e.pressed;
                i_explicit_mods <= e.emods;
                i_implicit_mods <= e.imods;
                i_link_active <= e.active;
                i_link_quiet <= e.quiet;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    int stall_phase;

    always @(posedge i_clk) begin
        t_report r;
        logic [15:0] got_slots [NUM_SLOTS];
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            i_ready <= (stall_phase % 200 < 60) ? 1'b1 :
                       ((stall_phase % 7) != 3 && $urandom_range(0, 3) != 0);
            if (o_valid && i_ready) begin
                n_reports++;
                if (expected_reports.size() == 0) begin
                    report_mismatch("unexpected report", 16'(o_report_kind), 16'd0);
                end else begin
                    r = expected_reports.pop_front();
                    got_slots = '{o_slot_0, o_slot_1, o_slot_2, o_slot_3, o_slot_4, o_slot_5};
                    if (o_report_kind !== r.kind)
                        report_mismatch("kind", 16'(o_report_kind), 16'(r.kind));
                    if (o_report_mods !== r.mods)
                        report_mismatch("mods", 16'(o_report_mods), 16'(r.mods));
                    foreach (got_slots[i])
                        if (got_slots[i] !== r.slots[i])
                            report_mismatch($sformatf("slot_%0d", i), got_slots[i], r.slots[i]);
                    if (o_handled !== r.handled)
                        report_mismatch("handled", 16'(o_handled), 16'(r.handled));
                    if (o_last !== r.last) report_mismatch("last", 16'(o_last), 16'(r.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
        end
    end

    initial begin
        errors = 0;
        n_events = 0;
        n_reports = 0;
        n_queued_replays = 0;
        stim_done = 0;
        timed_out = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_req_type = 1'b0;
        i_usage_page = 8'd0;
        i_keycode = 16'd0;
        i_pressed = 1'b0;
        i_explicit_mods = 8'd0;
        i_implicit_mods = 8'd0;
        i_link_active = 1'b0;
        i_link_quiet = 1'b0;
        key_slots = '{default: 8'd0};
        media_slots = '{default: 16'd0};
        exp_cnt = '{default: 8'd0};
        imp_cnt = '{default: 8'd0};
        exp_bits = 8'd0;
        imp_bits = 8'd0;
        prev_active = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait ((stim_done && !i_valid && expected_reports.size() == 0) || timed_out);
        if (!timed_out) begin
            repeat (50) @(posedge i_clk);
            $display("%0d events transferred, %0d reports checked, %0d replayed from quiet queues",
                     n_events, n_reports, n_queued_replays);
        end
        if (timed_out) begin
            $display("[FAIL] regression broken");
        end else if (errors == 0 && expected_reports.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
